// ----- hw/rtl/kfb_pkg.sv -----
package kfb_pkg;

  // Framing characters
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChKey = 8'h4B;
  localparam logic [7:0] ChLen = 8'h4C;

  // CRC-16/X.25, reflected form
  localparam logic [15:0] CrcPoly   = 16'h8408;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcXorOut = 16'hFFFF;

  // Position within the byte sequence that one request produces
  typedef enum logic [3:0] {
    STEP_SOH  = 4'd0,
    STEP_KCH  = 4'd1,
    STEP_KEY  = 4'd2,
    STEP_LCH  = 4'd3,
    STEP_LEN  = 4'd4,
    STEP_STX  = 4'd5,
    STEP_DATA = 4'd6,
    STEP_CRC  = 4'd7,
    STEP_ETX  = 4'd8
  } step_e;

endpackage

// ----- hw/rtl/kfb_crc8.sv -----
module kfb_crc8 import kfb_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  // Eight reflected shift/xor steps, one per data bit
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ----- hw/rtl/key_frame_builder_crc16.sv -----
// Frame builder with CRC-16/X.25 check byte. Each payload byte request on the
// slave stream carries the byte, the key, the length and a last flag; the
// first byte of a frame is preceded on the master stream by SOH, 'K', key,
// 'L', length, STX, and the byte marked last is followed by the low CRC byte
// and ETX (tuser high). Master tlast marks the final byte caused by each
// request. A held request emits one byte per cycle through the output register
// while the master stream is ready; a mid-frame request yields one byte, a
// first request 7, a closing one 3 and a one-byte frame 9; the next request is
// taken in the cycle its predecessor's last byte moves into the output register.
module key_frame_builder_crc16 import kfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] data_byte, [15:8] frame_key, [23:16] length_field
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o,  // run_last
  output logic        m_axis_tuser_o   // frame_end
);

  // Held request
  logic        hold_vld_q, hold_vld_d;
  logic [7:0]  data_q, key_q, len_q;
  logic        last_q, first_q;
  step_e       step_q, step_d;

  // Frame state
  logic        in_frame_q;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_base, crc_new;

  // Output register
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        out_end_q, out_end_d;

  logic out_adv, emit, final_step, s_acc;

  assign out_adv    = !out_vld_q || m_axis_tready_i;
  assign emit       = hold_vld_q && out_adv;
  assign final_step = last_q ? (step_q == STEP_ETX) : (step_q == STEP_DATA);
  assign s_axis_tready_o = !hold_vld_q || (emit && final_step);
  assign s_acc      = s_axis_tvalid_i && s_axis_tready_o;

  assign crc_base = first_q ? CrcInit : crc_q;

  kfb_crc8 u_crc (
    .crc_i  (crc_base),
    .data_i (data_q),
    .crc_o  (crc_new)
  );

  // Byte selection for the current step
  always_comb begin
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_end_d  = out_end_q;
    if (emit) begin
      out_last_d = 1'b0;
      out_end_d  = 1'b0;
      case (step_q)
        STEP_SOH:  out_byte_d = ChSoh;
        STEP_KCH:  out_byte_d = ChKey;
        STEP_KEY:  out_byte_d = key_q;
        STEP_LCH:  out_byte_d = ChLen;
        STEP_LEN:  out_byte_d = len_q;
        STEP_STX:  out_byte_d = ChStx;
        STEP_DATA: begin
          out_byte_d = data_q;
          out_last_d = !last_q;
        end
        STEP_CRC:  out_byte_d = crc_q[7:0] ^ CrcXorOut[7:0];
        STEP_ETX: begin
          out_byte_d = ChEtx;
          out_last_d = 1'b1;
          out_end_d  = 1'b1;
        end
        default:   out_byte_d = ChEtx;
      endcase
    end
  end

  // Output valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_adv) begin
      out_vld_d = emit;
    end
  end

  // Hold stage control and CRC
  always_comb begin
    hold_vld_d = hold_vld_q;
    step_d     = step_q;
    crc_d      = crc_q;
    if (emit) begin
      if (step_q == STEP_DATA) begin
        crc_d = crc_new;
      end
      if (final_step) begin
        hold_vld_d = 1'b0;
      end else begin
        step_d = step_e'(step_q + 4'd1);
      end
    end
    if (s_acc) begin
      hold_vld_d = 1'b1;
      step_d     = in_frame_q ? STEP_DATA : STEP_SOH;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      step_q     <= STEP_SOH;
      in_frame_q <= 1'b0;
      crc_q      <= CrcInit;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      step_q     <= step_d;
      crc_q      <= crc_d;
      out_vld_q  <= out_vld_d;
      if (s_acc) begin
        in_frame_q <= !s_axis_tlast_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
    if (s_acc) begin
      data_q  <= s_axis_tdata_i[7:0];
      key_q   <= s_axis_tdata_i[15:8];
      len_q   <= s_axis_tdata_i[23:16];
      last_q  <= s_axis_tlast_i;
      first_q <= !in_frame_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_end_q;

endmodule

// ----- tb/tb_key_frame_builder_crc16.sv -----
module tb_key_frame_builder_crc16;
  import kfb_pkg::*;

  // One byte of the framed output stream
  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  // Tracks header/CRC state and holds the bytes still owed by the block
  class frame_predictor;
    frame_byte_t pending_bytes[$];
    logic [15:0] crc_acc;
    bit          open_frame;
    int          mismatches;

    function new();
      crc_acc    = CrcInit;
      open_frame = 1'b0;
      mismatches = 0;
    endfunction

    // CRC-16/X.25, LSB first
    function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      return r;
    endfunction

    function void push(logic [7:0] octet, logic run_last, logic frame_end);
      frame_byte_t fb;
      fb.octet     = octet;
      fb.run_last  = run_last;
      fb.frame_end = frame_end;
      pending_bytes.push_back(fb);
    endfunction

    // Accepted payload request: queue every byte it produces
    function void take_payload(logic [7:0] data, logic [7:0] key, logic [7:0] len,
                               logic last);
      logic [15:0] fin;
      if (!open_frame) begin
        crc_acc = CrcInit;
        push(ChSoh, 1'b0, 1'b0);
        push(ChKey, 1'b0, 1'b0);
        push(key,   1'b0, 1'b0);
        push(ChLen, 1'b0, 1'b0);
        push(len,   1'b0, 1'b0);
        push(ChStx, 1'b0, 1'b0);
        open_frame = 1'b1;
      end
      crc_acc = crc_fold(crc_acc, data);
      push(data, !last, 1'b0);
      if (last) begin
        fin = crc_acc ^ CrcXorOut;
        push(fin[7:0], 1'b0, 1'b0);
        push(ChEtx, 1'b1, 1'b1);
        crc_acc    = CrcInit;
        open_frame = 1'b0;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Accepted output byte: compare with the oldest owed byte
    function void check_out_byte(logic [7:0] octet, logic run_last, logic frame_end);
      frame_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("unexpected byte %02h last=%0b end=%0b", octet, run_last, frame_end));
        return;
      end
      exp_b = pending_bytes.pop_front();
      if (exp_b.octet !== octet || exp_b.run_last !== run_last ||
          exp_b.frame_end !== frame_end)
        flag($sformatf("exp byte %02h last=%0b end=%0b, got %02h last=%0b end=%0b",
                       exp_b.octet, exp_b.run_last, exp_b.frame_end,
                       octet, run_last, frame_end));
    endfunction
  endclass

  typedef enum int {RX_FLOW, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [7:0]  m_axis_tdata_o;
  wire         m_axis_tlast_o;
  wire         m_axis_tuser_o;

  frame_predictor board = new();
  int           burst_left = 0;
  int           requests_sent = 0;
  rx_mode_e     rx_mode = RX_FLOW;
  logic [31:0]  rx_cycle = '0;

  key_frame_builder_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // Bursts of back-to-back requests separated by random idle gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      s_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Present one payload request and hold it until taken
  task automatic send_payload(logic [7:0] data, logic [7:0] key, logic [7:0] len,
                              logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= {len, key, data};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.take_payload(data, key, len, last);
    requests_sent++;
    pace();
  endtask

  // Whole frame of random content; key/len on later bytes are don't-care
  task automatic send_frame(int nbytes, logic [7:0] key, logic [7:0] len);
    for (int i = 0; i < nbytes; i++)
      send_payload(8'($urandom), i == 0 ? key : 8'($urandom), i == 0 ? len : 8'($urandom),
                   i == nbytes - 1);
  endtask

  // Receiver: checks every accepted byte, stalls according to a changing mode
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      board.check_out_byte(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 50 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FLOW:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_EVERY4: m_tready <= (rx_cycle[1:0] == 2'b11);
      default:   m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    int nbytes;
    int len_sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte frames at field extremes
    send_payload(8'h00, 8'h00, 8'h00, 1'b1);
    send_payload(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_payload(8'h80, 8'h01, 8'h01, 1'b1);
    // Key and length changed mid-frame must not show up
    send_payload(8'h00, 8'hA5, 8'h04, 1'b0);
    send_payload(8'hFF, 8'h5A, 8'hFF, 1'b0);
    send_payload(8'h5A, 8'h00, 8'h00, 1'b0);
    send_payload(8'h81, 8'hFF, 8'h11, 1'b1);
    // Length byte disagreeing with the byte count
    send_payload(8'h01, 8'h7E, 8'h10, 1'b0);
    send_payload(8'hFE, 8'h81, 8'hEF, 1'b0);
    send_payload(8'h33, 8'h18, 8'h00, 1'b1);
    // Back-to-back closes, then a longer frame with constant bytes
    send_payload(8'hC3, 8'h5A, 8'hA5, 1'b0);
    send_payload(8'h3C, 8'h00, 8'h00, 1'b1);
    for (int i = 0; i < 8; i++) send_payload(8'hFF, 8'h80, 8'h08, i == 7);

    // Random frames, mostly short
    while (requests_sent < 445) begin
      len_sel = $urandom_range(0, 19);
      if (len_sel < 14)      nbytes = $urandom_range(1, 6);
      else if (len_sel < 19) nbytes = $urandom_range(7, 20);
      else                   nbytes = $urandom_range(21, 60);
      send_frame(nbytes, 8'($urandom), $urandom_range(0, 1) ? 8'(nbytes) : 8'($urandom));
    end

    s_tvalid <= 1'b0;
    while (board.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
